/* hw/rtl/ps2mt_pkg.sv */
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

  // register file
  localparam int PS2MT_ADDR_W = 3;
  localparam int PS2MT_DATA_W = 32;
  localparam logic PS2MT_REG_COLUMNS = 1'b0;
  localparam logic PS2MT_REG_ROWS = 1'b1;
  localparam logic [7:0] PS2MT_RESET_COLUMNS = 8'd80;
  localparam logic [7:0] PS2MT_RESET_ROWS = 8'd25;

  // cursor home position
  localparam logic [7:0] PS2MT_RESET_COL = 8'd40;
  localparam logic [7:0] PS2MT_RESET_ROW = 8'd12;

  // packet assembly
  localparam logic [1:0] PS2MT_FIRST_PHASE = 2'd0;
  localparam logic [1:0] PS2MT_LAST_PHASE = 2'd2;
  localparam logic [2:0] PS2MT_BUTTON_MASK = 3'b111;

  // queue between packet assembly and cursor update
  localparam int PS2MT_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] screen_columns;
    logic [7:0] screen_rows;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] dx;
    logic [7:0] dy;
  } packet_t;

  typedef struct packed {
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic [7:0] old_col;
    logic [7:0] old_row;
    logic [2:0] button_state;
    logic [2:0] pressed_mask;
    logic [2:0] released_mask;
    logic       cursor_moved;
  } update_t;

endpackage

/* hw/rtl/ps2mt_chan_if.sv */
// ----------------------------------------------------------------------------
// ps2mt channel interfaces
// Valid/ready channels for controller bytes in and cursor reports out.
// ----------------------------------------------------------------------------
interface ps2mt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       aux_data;

  modport source (output valid, rx_byte, aux_data, input ready);
  modport sink (input valid, rx_byte, aux_data, output ready);
endinterface

interface ps2mt_report_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cursor_col;
  logic [7:0]  cursor_row;
  logic [2:0]  button_state;
  logic [2:0]  pressed_mask;
  logic [2:0]  released_mask;
  logic        cursor_moved;
  logic [15:0] old_cell_index;
  logic [15:0] new_cell_index;

  modport source (
    output valid, cursor_col, cursor_row, button_state, pressed_mask,
           released_mask, cursor_moved, old_cell_index, new_cell_index,
    input  ready
  );
  modport sink (
    input  valid, cursor_col, cursor_row, button_state, pressed_mask,
           released_mask, cursor_moved, old_cell_index, new_cell_index,
    output ready
  );
endinterface

/* hw/rtl/ps2_mouse_packet_cursor_tracker.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// PS/2 mouse three-byte packet decoder with text-cursor tracking.
// ----------------------------------------------------------------------------
// a packet's last byte passes through the update register and then the output register into a report
// throughput: one word per cycle while the packet queue has room, set by the cursor add/clamp loop
// reset: cursor at column 40 row 12, 80x25 screen, no buttons, packet position 0
// the packet queue and both back stages come out of reset empty
module ps2_mouse_packet_cursor_tracker #(
  parameter int QUEUE_DEPTH = ps2mt_pkg::PS2MT_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  ps2mt_byte_if.sink                    bytes,
  ps2mt_report_if.source                reports,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ps2mt_pkg::PS2MT_ADDR_W-1:0] paddr,
  input  logic [ps2mt_pkg::PS2MT_DATA_W-1:0] pwdata,
  output logic [ps2mt_pkg::PS2MT_DATA_W-1:0] prdata,
  output logic                          pready
);

  ps2mt_pkg::cfg_t    cfg;
  ps2mt_pkg::packet_t push_pkt;
  ps2mt_pkg::packet_t pop_pkt;
  logic               push_valid;
  logic               push_ready;
  logic               pop_valid;
  logic               pop_ready;
  logic               reg_write;
  logic               reg_sel;

  // register port
  assign pready = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_columns <= ps2mt_pkg::PS2MT_RESET_COLUMNS;
      cfg.screen_rows <= ps2mt_pkg::PS2MT_RESET_ROWS;
    end else if (reg_write) begin
      unique case (reg_sel)
        ps2mt_pkg::PS2MT_REG_COLUMNS: cfg.screen_columns <= pwdata[7:0];
        ps2mt_pkg::PS2MT_REG_ROWS:    cfg.screen_rows <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ps2mt_pkg::PS2MT_REG_COLUMNS: prdata = {24'd0, cfg.screen_columns};
      ps2mt_pkg::PS2MT_REG_ROWS:    prdata = {24'd0, cfg.screen_rows};
      default:                      prdata = '0;
    endcase
  end

  // packet assembly
  ps2mt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .push_pkt   (push_pkt),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // packet queue
  ps2mt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_pkt   (push_pkt),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_pkt    (pop_pkt),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // cursor update and report
  ps2mt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pkt       (pop_pkt),
    .pkt_valid (pop_valid),
    .pkt_ready (pop_ready),
    .reports   (reports)
  );

  // a moved cursor's column lies on screen
  assert property (@(posedge clk) disable iff (rst)
    (reports.valid && reports.cursor_moved) |->
      ((cfg.screen_columns == 8'd0) ? (reports.cursor_col == 8'd0)
                                    : (reports.cursor_col < cfg.screen_columns)))
    else $error("cursor column off screen after move");

  // no movement keeps the highlighted cell
  assert property (@(posedge clk) disable iff (rst)
    (reports.valid && !reports.cursor_moved) |->
      (reports.old_cell_index == reports.new_cell_index))
    else $error("cell changed without movement");

  // edge masks are disjoint and press edges follow the button state
  assert property (@(posedge clk) disable iff (rst)
    reports.valid |->
      (((reports.pressed_mask & reports.released_mask) == 3'd0) &&
       ((reports.pressed_mask & ~reports.button_state) == 3'd0)))
    else $error("inconsistent button edge masks");

  // a packet byte is never taken while the queue is full
  assert property (@(posedge clk) disable iff (rst)
    (bytes.valid && bytes.ready) |-> push_ready)
    else $error("word taken with packet queue full");

endmodule

/* hw/rtl/ps2mt_front.sv */
// ----------------------------------------------------------------------------
// ps2mt_front
// Filters mouse bytes and assembles them into three-byte packets.
// ----------------------------------------------------------------------------
module ps2mt_front (
  input  logic               clk,
  input  logic               rst,
  ps2mt_byte_if.sink         bytes,
  output ps2mt_pkg::packet_t push_pkt,
  output logic               push_valid,
  input  logic               push_ready
);

  logic [1:0] byte_phase;
  logic [1:0] byte_phase_next;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic       take;

  // a word is taken only when a completed packet could be queued
  assign bytes.ready = push_ready;
  assign take = bytes.valid && bytes.ready && bytes.aux_data;

  // third byte goes straight into the queue with the two held ones
  assign push_valid = bytes.valid && bytes.aux_data &&
                      (byte_phase == ps2mt_pkg::PS2MT_LAST_PHASE);
  assign push_pkt = '{byte0: byte0, dx: byte1, dy: bytes.rx_byte};

  // packet position
  always_comb begin
    byte_phase_next = byte_phase;
    if (take) begin
      if (byte_phase >= ps2mt_pkg::PS2MT_LAST_PHASE) begin
        byte_phase_next = ps2mt_pkg::PS2MT_FIRST_PHASE;
      end else begin
        byte_phase_next = byte_phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= ps2mt_pkg::PS2MT_FIRST_PHASE;
    end else begin
      byte_phase <= byte_phase_next;
    end
  end

  // held packet bytes
  always_ff @(posedge clk) begin
    if (take && (byte_phase == 2'd0)) begin
      byte0 <= bytes.rx_byte;
    end
    if (take && (byte_phase == 2'd1)) begin
      byte1 <= bytes.rx_byte;
    end
  end

endmodule

/* hw/rtl/ps2mt_queue.sv */
// ----------------------------------------------------------------------------
// ps2mt_queue
// Short packet queue between packet assembly and cursor update.
// ----------------------------------------------------------------------------
module ps2mt_queue #(
  parameter int DEPTH = ps2mt_pkg::PS2MT_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  ps2mt_pkg::packet_t push_pkt,
  input  logic               push_valid,
  output logic               push_ready,
  output ps2mt_pkg::packet_t pop_pkt,
  output logic               pop_valid,
  input  logic               pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ps2mt_pkg::packet_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop_pkt = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/ps2mt_back.sv */
// ----------------------------------------------------------------------------
// ps2mt_back
// Applies packet movement to the cursor and builds the button/cell report.
// ----------------------------------------------------------------------------
module ps2mt_back (
  input  logic               clk,
  input  logic               rst,
  input  ps2mt_pkg::cfg_t    cfg,
  input  ps2mt_pkg::packet_t pkt,
  input  logic               pkt_valid,
  output logic               pkt_ready,
  ps2mt_report_if.source     reports
);

  logic [7:0] cursor_col_reg;
  logic [7:0] cursor_row_reg;
  logic [2:0] last_buttons;

  ps2mt_pkg::update_t upd;
  ps2mt_pkg::update_t upd_next;
  logic               upd_valid;
  logic               out_open;
  logic               upd_open;
  logic               take;

  logic signed [9:0] nx;
  logic signed [9:0] ny;
  logic signed [9:0] col_pos;
  logic signed [9:0] row_pos;
  logic signed [9:0] col_size;
  logic signed [9:0] row_size;
  logic [7:0]        col_new;
  logic [7:0]        row_new;
  logic [2:0]        btn;
  logic              moved;
  logic [15:0]       old_cell;
  logic [15:0]       new_cell;

  assign out_open = !reports.valid || reports.ready;
  assign upd_open = !upd_valid || out_open;
  assign pkt_ready = upd_open;
  assign take = pkt_valid && pkt_ready;

  // movement with clamping, upper bound first and then zero
  always_comb begin
    moved = (pkt.dx != 8'd0) || (pkt.dy != 8'd0);
    col_size = $signed({2'b00, cfg.screen_columns});
    row_size = $signed({2'b00, cfg.screen_rows});
    nx = $signed({2'b00, cursor_col_reg}) + 10'(signed'(pkt.dx));
    ny = $signed({2'b00, cursor_row_reg}) - 10'(signed'(pkt.dy));
    col_pos = (nx >= col_size) ? col_size - 10'sd1 : nx;
    row_pos = (ny >= row_size) ? row_size - 10'sd1 : ny;
    col_new = (col_pos < 10'sd0) ? 8'd0 : col_pos[7:0];
    row_new = (row_pos < 10'sd0) ? 8'd0 : row_pos[7:0];
    btn = pkt.byte0[2:0] & ps2mt_pkg::PS2MT_BUTTON_MASK;
    upd_next.cursor_col = moved ? col_new : cursor_col_reg;
    upd_next.cursor_row = moved ? row_new : cursor_row_reg;
    upd_next.old_col = cursor_col_reg;
    upd_next.old_row = cursor_row_reg;
    upd_next.button_state = btn;
    upd_next.pressed_mask = btn & ~last_buttons;
    upd_next.released_mask = last_buttons & ~btn;
    upd_next.cursor_moved = moved;
  end

  // cursor and button history
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col_reg <= ps2mt_pkg::PS2MT_RESET_COL;
      cursor_row_reg <= ps2mt_pkg::PS2MT_RESET_ROW;
      last_buttons <= '0;
    end else if (take) begin
      cursor_col_reg <= upd_next.cursor_col;
      cursor_row_reg <= upd_next.cursor_row;
      last_buttons <= upd_next.button_state;
    end
  end

  // update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
    end else if (upd_open) begin
      upd_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      upd <= upd_next;
    end
  end

  // cell indices, row times columns plus column
  assign old_cell = (16'(upd.old_row) * 16'(cfg.screen_columns)) + 16'(upd.old_col);
  assign new_cell = (16'(upd.cursor_row) * 16'(cfg.screen_columns)) + 16'(upd.cursor_col);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      reports.valid <= 1'b0;
    end else if (out_open) begin
      reports.valid <= upd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && upd_valid) begin
      reports.cursor_col <= upd.cursor_col;
      reports.cursor_row <= upd.cursor_row;
      reports.button_state <= upd.button_state;
      reports.pressed_mask <= upd.pressed_mask;
      reports.released_mask <= upd.released_mask;
      reports.cursor_moved <= upd.cursor_moved;
      reports.old_cell_index <= old_cell;
      reports.new_cell_index <= new_cell;
    end
  end

endmodule
